FILE: hdl/frustum_box_cull_macros.svh
// Assertion macros for the frustum box cull port checker.
`ifndef FRUSTUM_BOX_CULL_MACROS_SVH
`define FRUSTUM_BOX_CULL_MACROS_SVH

// Plain clocked assertion, disabled while reset is active.
`define FBC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Clocked implication, overlapping form.
`define FBC_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  `FBC_ASSERT(name, clk, rstn, (ante) |-> (cons))

`endif

FILE: hdl/fbc_pkg.sv
// Types and constants for the frustum box cull block.
package fbc_pkg;

  localparam int unsigned PlaneCount = 6;
  localparam int unsigned CornerCount = 8;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned DShift = 14;
  localparam int unsigned ProdW = 2 * CoordW;
  // three products plus the scaled offset, with headroom for the carries
  localparam int unsigned SumW = ProdW + 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLeft   = 3'd0,
    CfgRight  = 3'd1,
    CfgBottom = 3'd2,
    CfgTop    = 3'd3,
    CfgNear   = 3'd4,
    CfgFar    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VisOutside   = 2'd0,
    VisIntersect = 2'd1,
    VisInside    = 2'd2
  } vis_e;

  // Packed so that a 64-bit register word casts straight onto it.
  typedef struct packed {
    logic signed [CoordW-1:0] a;
    logic signed [CoordW-1:0] b;
    logic signed [CoordW-1:0] c;
    logic signed [CoordW-1:0] d;
  } plane_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic any_front;
    logic all_front;
  } plane_res_t;

endpackage

FILE: hdl/fbc_plane_regs.sv
// Configuration register file holding the six frustum planes.
module fbc_plane_regs
  import fbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output plane_t              planes_o [PlaneCount]
);

  logic [PlaneCount-1:0] wr_sel;
  plane_t                planes_q [PlaneCount];

  always_comb begin
    wr_sel = '0;
    unique case (cfg_idx_e'(cfg_index_i))
      CfgLeft:   wr_sel[0] = cfg_we_i;
      CfgRight:  wr_sel[1] = cfg_we_i;
      CfgBottom: wr_sel[2] = cfg_we_i;
      CfgTop:    wr_sel[3] = cfg_we_i;
      CfgNear:   wr_sel[4] = cfg_we_i;
      CfgFar:    wr_sel[5] = cfg_we_i;
      // drop writes beyond the register list
      default:   wr_sel = '0;
    endcase
  end

  for (genvar p = 0; p < PlaneCount; p++) begin : g_plane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        planes_q[p] <= '0;
      end else if (wr_sel[p]) begin
        planes_q[p] <= plane_t'(cfg_data_i);
      end
    end
    assign planes_o[p] = planes_q[p];
  end

endmodule

FILE: hdl/fbc_plane_test.sv
// Tests the eight corners of a box against one plane.
module fbc_plane_test
  import fbc_pkg::*;
(
  input  plane_t     plane_i,
  input  box_t       box_i,
  output plane_res_t res_o
);

  logic signed [ProdW-1:0] ax_lo, ax_hi, by_lo, by_hi, cz_lo, cz_hi;
  logic signed [SumW-1:0]  d_term;
  logic [CornerCount-1:0]  front;

  function automatic logic signed [ProdW-1:0] smul(input logic signed [CoordW-1:0] u,
                                                   input logic signed [CoordW-1:0] v);
    smul = $signed({{CoordW{u[CoordW-1]}}, u}) * $signed({{CoordW{v[CoordW-1]}}, v});
  endfunction

  function automatic logic signed [SumW-1:0] ext(input logic signed [ProdW-1:0] p);
    ext = $signed({{(SumW-ProdW){p[ProdW-1]}}, p});
  endfunction

  assign ax_lo = smul(plane_i.a, box_i.min_x);
  assign ax_hi = smul(plane_i.a, box_i.max_x);
  assign by_lo = smul(plane_i.b, box_i.min_y);
  assign by_hi = smul(plane_i.b, box_i.max_y);
  assign cz_lo = smul(plane_i.c, box_i.min_z);
  assign cz_hi = smul(plane_i.c, box_i.max_z);

  assign d_term = $signed({{(SumW-CoordW-DShift){plane_i.d[CoordW-1]}}, plane_i.d,
                           {DShift{1'b0}}});

  // corner k takes the upper x, y, z for bits 2, 1, 0 of k
  for (genvar k = 0; k < CornerCount; k++) begin : g_corner
    logic signed [SumW-1:0] sum;
    assign sum = ext((k & 4) != 0 ? ax_hi : ax_lo)
               + ext((k & 2) != 0 ? by_hi : by_lo)
               + ext((k & 1) != 0 ? cz_hi : cz_lo)
               + d_term;
    // strictly positive: a zero sum is not in front
    assign front[k] = !sum[SumW-1] && (sum != '0);
  end

  assign res_o.any_front = |front;
  assign res_o.all_front = &front;

endmodule

FILE: hdl/frustum_box_cull.sv
// Top level of the frustum box cull block.
//
// Classifies an axis-aligned box against six frustum planes.
// Configuration: write a plane word (a, b, c in Q1.14, d in scene units)
// through cfg_valid_i/cfg_index_i/cfg_data_i while no box is in flight;
// cfg_ready_o is always high and indexes past the far plane are dropped.
// Input: one box per transfer on in_valid_i/in_ready_o.
// Output: one visibility code per box on out_valid_o/out_ready_i
// (0 outside, 1 intersecting, 2 fully inside), in input order.
// The box is registered, then the 48 corner tests and the classification
// run combinationally into the result register. Throughput is one box
// per cycle while out_ready_i stays high.
// A stalled receiver holds the result register; the input register still
// takes a box if it is empty or the result register frees up in the same
// cycle, otherwise in_ready_o drops until out_ready_i returns.
// Reset clears all planes to zero (every box reads as outside) and empties
// both pipeline stages.
module frustum_box_cull
  import fbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  min_x_i,
  input  logic signed [15:0]  min_y_i,
  input  logic signed [15:0]  min_z_i,
  input  logic signed [15:0]  max_x_i,
  input  logic signed [15:0]  max_y_i,
  input  logic signed [15:0]  max_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          visibility_o
);

  plane_t                planes [PlaneCount];
  plane_res_t            res [PlaneCount];
  logic [PlaneCount-1:0] any_front, all_front;

  box_t  box_q;
  logic  box_valid_q;
  logic  box_adv;
  vis_e  vis_d, vis_q;
  logic  out_valid_q;

  assign cfg_ready_o = 1'b1;

  fbc_plane_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (planes)
  );

  // move the box into the result stage when that stage is empty or draining
  assign box_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !box_valid_q || box_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      box_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      box_q <= '{min_x: min_x_i, min_y: min_y_i, min_z: min_z_i,
                 max_x: max_x_i, max_y: max_y_i, max_z: max_z_i};
    end
  end

  for (genvar p = 0; p < PlaneCount; p++) begin : g_test
    fbc_plane_test u_test (
      .plane_i (planes[p]),
      .box_i   (box_q),
      .res_o   (res[p])
    );
    assign any_front[p] = res[p].any_front;
    assign all_front[p] = res[p].all_front;
  end

  always_comb begin
    if (!(&any_front)) begin
      vis_d = VisOutside;
    end else if (&all_front) begin
      vis_d = VisInside;
    end else begin
      vis_d = VisIntersect;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (box_adv) begin
      out_valid_q <= box_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_adv && box_valid_q) begin
      vis_q <= vis_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign visibility_o = vis_q;

endmodule

FILE: hdl/fbc_checker.sv
// Port-level checker for the frustum box cull block, with its bind.
`include "frustum_box_cull_macros.svh"

module fbc_checker
  import fbc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [1:0]          visibility_o
);

  `FBC_ASSERT_IMPL(a_vis_legal, clk_i, rst_ni, out_valid_o, visibility_o <= VisInside)
  `FBC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(visibility_o))
  `FBC_ASSERT_IMPL(a_idle_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `FBC_ASSERT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_o) ##1 !out_valid_o |=> out_valid_o)

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);

FILE: tb/cull_checker.sv
// Checker for the frustum box cull block: predicts each visibility code and compares.
module cull_checker
  import fbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic signed [15:0]  min_x_i,
  input  logic signed [15:0]  min_y_i,
  input  logic signed [15:0]  min_z_i,
  input  logic signed [15:0]  max_x_i,
  input  logic signed [15:0]  max_y_i,
  input  logic signed [15:0]  max_z_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [1:0]          visibility_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PrintLimit = 100;

  plane_t plane_regs [PlaneCount];
  vis_e   vis_expected [$];
  vis_e   want_vis;
  int     result_idx = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count_o < PrintLimit) begin
      $display("[%0t] cull mismatch: %s", $time, what);
    end
    mismatch_count_o++;
  endtask

  // Corners strictly in front of one plane; the offset is scaled up to Q.14.
  function automatic int count_front(input plane_t p, input box_t bx);
    longint x;
    longint y;
    longint z;
    longint s;
    int     n;
    n = 0;
    for (int k = 0; k < CornerCount; k++) begin
      x = k[2] ? bx.max_x : bx.min_x;
      y = k[1] ? bx.max_y : bx.min_y;
      z = k[0] ? bx.max_z : bx.min_z;
      s = longint'(p.a) * x + longint'(p.b) * y + longint'(p.c) * z
        + (longint'(p.d) <<< DShift);
      if (s > 0) n++;
    end
    return n;
  endfunction

  function automatic vis_e classify_box(input box_t bx);
    int n;
    int total;
    bit outside;
    total   = 0;
    outside = 1'b0;
    for (int i = 0; i < PlaneCount; i++) begin
      n = count_front(plane_regs[i], bx);
      if (n == 0) outside = 1'b1;
      total += n;
    end
    if (outside) return VisOutside;
    if (total == PlaneCount * CornerCount) return VisInside;
    return VisIntersect;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (plane_regs[i]) plane_regs[i] <= '0;
      vis_expected.delete();
      pending_o <= 0;
    end else begin
      // indexes past the far plane are dropped by the block
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < PlaneCount) begin
        plane_regs[cfg_index_i] <= plane_t'(cfg_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (vis_expected.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending (got %0d)",
                                    result_idx, visibility_i));
        end else begin
          want_vis = vis_expected.pop_front();
          if (visibility_i !== want_vis) begin
            report_mismatch($sformatf("result %0d: visibility got %0d, want %0d",
                                      result_idx, visibility_i, want_vis));
          end
        end
        result_idx++;
      end
      if (in_valid_i && in_ready_i) begin
        vis_expected.insert(vis_expected.size(),
                            classify_box(box_t'({min_x_i, min_y_i, min_z_i,
                                                 max_x_i, max_y_i, max_z_i})));
      end
      pending_o <= vis_expected.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Top of the frustum box cull testbench: clock, reset, box and plane stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fbc_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 12;
  localparam int RandomPhases  = 5;
  localparam int ItemsPerPhase = 280;
  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 4;
  localparam int CycleLimit    = 300000;

  localparam logic [CfgIdxW-1:0] IdxSpareFirst = CfgIdxW'(PlaneCount);
  localparam logic [CfgIdxW-1:0] IdxSpareLast  = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic signed [15:0]  min_x_i;
  logic signed [15:0]  min_y_i;
  logic signed [15:0]  min_z_i;
  logic signed [15:0]  max_x_i;
  logic signed [15:0]  max_y_i;
  logic signed [15:0]  max_z_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          visibility_o;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int hold_req    = 0;
  int hold_done   = 0;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;

  logic [CfgDataW-1:0] frustum_words [PlaneCount];
  int ext_x = 1000;
  int ext_y = 1000;
  int ext_z = 1000;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  frustum_box_cull u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .min_x_i      (min_x_i),
    .min_y_i      (min_y_i),
    .min_z_i      (min_z_i),
    .max_x_i      (max_x_i),
    .max_y_i      (max_y_i),
    .max_z_i      (max_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .visibility_o (visibility_o)
  );

  cull_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .min_x_i          (min_x_i),
    .min_y_i          (min_y_i),
    .min_z_i          (min_z_i),
    .max_x_i          (max_x_i),
    .max_y_i          (max_y_i),
    .max_z_i          (max_z_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .visibility_i     (visibility_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  function automatic box_t mk_box(input int x0, input int y0, input int z0,
                                  input int x1, input int y1, input int z1);
    return {16'(x0), 16'(y0), 16'(z0), 16'(x1), 16'(y1), 16'(z1)};
  endfunction

  function automatic logic [CfgDataW-1:0] plane_word(input int a, input int b,
                                                     input int c, input int d);
    return {16'(a), 16'(b), 16'(c), 16'(d)};
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int sym_rand(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Boxes scattered around the current frustum, with a few raw, inverted
  // and face-touching ones mixed in.
  function automatic box_t rand_box();
    box_t bx;
    box_t t;
    int   sel;
    int   e [3];
    int   c [3];
    int   h [3];
    e   = '{ext_x, ext_y, ext_z};
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      bx = box_t'({$urandom, $urandom, $urandom});
    end else begin
      for (int i = 0; i < 3; i++) begin
        c[i] = sym_rand(2 * e[i]);
        h[i] = $urandom_range(0, e[i]);
      end
      bx = mk_box(clamp16(c[0] - h[0]), clamp16(c[1] - h[1]), clamp16(c[2] - h[2]),
                  clamp16(c[0] + h[0]), clamp16(c[1] + h[1]), clamp16(c[2] + h[2]));
      if (sel == 1) begin
        t  = bx;
        bx = {t.max_x, t.max_y, t.max_z, t.min_x, t.min_y, t.min_z};
      end else if (sel == 2) begin
        bx.min_x = 16'(-e[0]);
        bx.max_x = 16'(-e[0]);
      end
    end
    return bx;
  endfunction

  task automatic make_rand_frustum(input bit tilted);
    int n;
    ext_x = $urandom_range(50, 12000);
    ext_y = $urandom_range(50, 12000);
    ext_z = $urandom_range(50, 12000);
    n = tilted ? 16384 - int'($urandom_range(0, 1500)) : 16384;
    frustum_words[CfgLeft]   = plane_word( n, tilted ? sym_rand(1500) : 0,
                                          tilted ? sym_rand(1500) : 0, ext_x);
    frustum_words[CfgRight]  = plane_word(-n, tilted ? sym_rand(1500) : 0,
                                          tilted ? sym_rand(1500) : 0, ext_x);
    frustum_words[CfgBottom] = plane_word(tilted ? sym_rand(1500) : 0,  n,
                                          tilted ? sym_rand(1500) : 0, ext_y);
    frustum_words[CfgTop]    = plane_word(tilted ? sym_rand(1500) : 0, -n,
                                          tilted ? sym_rand(1500) : 0, ext_y);
    frustum_words[CfgNear]   = plane_word(tilted ? sym_rand(1500) : 0,
                                          tilted ? sym_rand(1500) : 0,  n, ext_z);
    frustum_words[CfgFar]    = plane_word(tilted ? sym_rand(1500) : 0,
                                          tilted ? sym_rand(1500) : 0, -n, ext_z);
  endtask

  // Write all six planes back to back, then poke the unused indexes.
  task automatic load_frustum();
    for (int i = 0; i < PlaneCount; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= frustum_words[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_index_i <= IdxSpareFirst;
    cfg_data_i  <= {$urandom, $urandom};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= IdxSpareLast;
    cfg_data_i  <= {$urandom, $urandom};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_box(input box_t bx);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    min_x_i    <= bx.min_x;
    min_y_i    <= bx.min_y;
    min_z_i    <= bx.min_z;
    max_x_i    <= bx.max_x;
    max_y_i    <= bx.max_y;
    max_z_i    <= bx.max_z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, then wait for every pending result and let the pipe settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    min_x_i     <= '0;
    min_y_i     <= '0;
    min_z_i     <= '0;
    max_x_i     <= '0;
    max_y_i     <= '0;
    max_z_i     <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // planes still at reset: every box is outside
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
    wait_idle();

    // axis-aligned cube of half size 1000
    frustum_words[CfgLeft]   = plane_word( 16384, 0, 0, 1000);
    frustum_words[CfgRight]  = plane_word(-16384, 0, 0, 1000);
    frustum_words[CfgBottom] = plane_word(0,  16384, 0, 1000);
    frustum_words[CfgTop]    = plane_word(0, -16384, 0, 1000);
    frustum_words[CfgNear]   = plane_word(0, 0,  16384, 1000);
    frustum_words[CfgFar]    = plane_word(0, 0, -16384, 1000);
    load_frustum();
    send_box(mk_box(-10, -10, -10, 10, 10, 10));
    send_box(mk_box(-2000, -10, -10, 0, 10, 10));
    send_box(mk_box(2000, 0, 0, 3000, 10, 10));
    send_box(mk_box(-1000, 0, 0, -1000, 5, 5));        // flat on the left face
    send_box(mk_box(-999, -999, -999, 999, 999, 999));
    send_box(mk_box(-999, -999, -999, 1000, 999, 999)); // one face on the right plane
    send_box(mk_box(10, 10, 10, -10, -10, -10));        // min above max
    send_box(mk_box(500, 0, 0, -3000, 0, 0));
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    wait_idle();

    // extreme normals and offsets
    frustum_words[CfgLeft]   = plane_word(32767, 0, 0, -32768);
    frustum_words[CfgRight]  = plane_word(-32768, 0, 0, 32767);
    frustum_words[CfgBottom] = plane_word(0, 32767, -32768, 32767);
    frustum_words[CfgTop]    = plane_word(0, -32768, 32767, 32767);
    frustum_words[CfgNear]   = plane_word(-32768, -32768, -32768, -32768);
    frustum_words[CfgFar]    = plane_word(32767, 32767, 32767, 32767);
    load_frustum();
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
    send_box(mk_box(20000, -100, -100, 30000, 100, 100));
    send_box(mk_box(-32768, 32767, -32768, 32767, -32768, 32767));
    wait_idle();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 3) begin
        foreach (frustum_words[i]) frustum_words[i] = {$urandom, $urandom};
        ext_x = 16000;
        ext_y = 16000;
        ext_z = 16000;
      end else begin
        make_rand_frustum(phase[0]);
      end
      load_frustum();
      // stall the output for a long stretch so the input backs up
      if (phase == 1 || phase == 3) hold_req++;
      repeat (ItemsPerPhase) send_box(rand_box());
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req != hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done++;
      end
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fbc_pkg.sv
hdl/fbc_plane_regs.sv
hdl/fbc_plane_test.sv
hdl/frustum_box_cull.sv
hdl/fbc_checker.sv
tb/cull_checker.sv
tb/tb_top.sv
